[rtl/lvm_pkg.sv]
package lvm_pkg;

   localparam int LVM_FRAC_BITS = 16;
   localparam int WORD_W = 32;

   // the largest normalized magnitude sits in [2^29, 2^30)
   localparam int NORM_W = 30;
   localparam int NORM_TOP = 29;

   // widest value handed to the saturation function
   localparam int SAT_IN_W = 72;

   localparam logic [1:0] ROW_SIDE = 2'd0;
   localparam logic [1:0] ROW_UP   = 2'd1;
   localparam logic [1:0] ROW_FWD  = 2'd2;
   localparam logic [1:0] ROW_LAST = 2'd3;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_IN_W-1:0] v);
      logic [SAT_IN_W-WORD_W:0] hi;
      hi = v[SAT_IN_W-1:WORD_W-1];
      if (hi == '0 || hi == '1) begin
         return v[WORD_W-1:0];
      end else if (v[SAT_IN_W-1]) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

endpackage

[rtl/lvm_if.sv]
interface lvm_req_if import lvm_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [WORD_W-1:0] eye_x;
   logic signed [WORD_W-1:0] eye_y;
   logic signed [WORD_W-1:0] eye_z;
   logic signed [WORD_W-1:0] target_x;
   logic signed [WORD_W-1:0] target_y;
   logic signed [WORD_W-1:0] target_z;
   logic signed [WORD_W-1:0] upvec_x;
   logic signed [WORD_W-1:0] upvec_y;
   logic signed [WORD_W-1:0] upvec_z;

   modport source (
      output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
             upvec_x, upvec_y, upvec_z,
      input  ready
   );
   modport sink (
      input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
             upvec_x, upvec_y, upvec_z,
      output ready
   );
endinterface

interface lvm_rsp_if import lvm_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] row_index;
   logic signed [WORD_W-1:0] elem0;
   logic signed [WORD_W-1:0] elem1;
   logic signed [WORD_W-1:0] elem2;
   logic signed [WORD_W-1:0] elem3;
   logic last_row;
   logic degenerate;

   modport source (
      output valid, row_index, elem0, elem1, elem2, elem3, last_row, degenerate,
      input  ready
   );
   modport sink (
      input  valid, row_index, elem0, elem1, elem2, elem3, last_row, degenerate,
      output ready
   );
endinterface

[rtl/lvm_norm.sv]
module lvm_norm import lvm_pkg::*; #(
   parameter int FRAC_BITS = LVM_FRAC_BITS,
   parameter int IN_W = WORD_W + 1,
   parameter int SIDE_W = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_vld,
   input  logic signed [IN_W-1:0] in_vec [3],
   input  logic [SIDE_W-1:0] in_side,
   output logic out_vld,
   output logic signed [FRAC_BITS+1:0] out_vec [3],
   output logic out_zero,
   output logic [SIDE_W-1:0] out_side
);

   localparam int MW = NORM_W;
   localparam int RW = MW + 1;
   localparam int SQW = 2 * RW;
   localparam int QW = FRAC_BITS + 2;
   localparam int NUMW = MW + FRAC_BITS + 1;
   localparam int DW = RW + QW;
   localparam int PW = $clog2(IN_W);

   // magnitudes and largest one
   logic a_vld_ff;
   logic [IN_W-1:0] a_mag_ff [3];
   logic [IN_W-1:0] a_max_ff;
   logic [2:0] a_neg_ff;
   logic [SIDE_W-1:0] a_side_ff;
   logic [IN_W-1:0] a_mag_in [3];
   logic [IN_W-1:0] a_max_in;
   logic [IN_W-1:0] a_m01;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
      end
      a_m01 = (a_mag_in[0] > a_mag_in[1]) ? a_mag_in[0] : a_mag_in[1];
      a_max_in = (a_m01 > a_mag_in[2]) ? a_m01 : a_mag_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= in_vld;
      end
      if (adv) begin
         a_mag_ff <= a_mag_in;
         a_max_ff <= a_max_in;
         a_neg_ff <= {in_vec[2][IN_W-1], in_vec[1][IN_W-1], in_vec[0][IN_W-1]};
         a_side_ff <= in_side;
      end
   end

   // leading one of the largest magnitude
   logic b_vld_ff;
   logic [PW-1:0] b_pos_ff;
   logic b_zero_ff;
   logic [IN_W-1:0] b_mag_ff [3];
   logic [2:0] b_neg_ff;
   logic [SIDE_W-1:0] b_side_ff;
   logic [PW-1:0] b_pos_in;

   always_comb begin
      b_pos_in = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (a_max_ff[b]) begin
            b_pos_in = PW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
      if (adv) begin
         b_pos_ff <= b_pos_in;
         b_zero_ff <= (a_max_ff == '0);
         b_mag_ff <= a_mag_ff;
         b_neg_ff <= a_neg_ff;
         b_side_ff <= a_side_ff;
      end
   end

   // common shift so the top magnitude lands on bit NORM_TOP
   logic c_vld_ff;
   logic [MW-1:0] c_m_ff [3];
   logic c_zero_ff;
   logic [2:0] c_neg_ff;
   logic [SIDE_W-1:0] c_side_ff;
   logic [MW-1:0] c_m_in [3];
   logic [PW-1:0] c_rsh;
   logic [PW-1:0] c_lsh;
   logic [IN_W-1:0] c_sh [3];

   always_comb begin
      c_rsh = b_pos_ff - PW'(NORM_TOP);
      c_lsh = PW'(NORM_TOP) - b_pos_ff;
      for (int i = 0; i < 3; i++) begin
         c_sh[i] = (b_pos_ff >= PW'(NORM_TOP)) ? (b_mag_ff[i] >> c_rsh) : (b_mag_ff[i] << c_lsh);
         c_m_in[i] = c_sh[i][MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
      if (adv) begin
         c_m_ff <= c_m_in;
         c_zero_ff <= b_zero_ff;
         c_neg_ff <= b_neg_ff;
         c_side_ff <= b_side_ff;
      end
   end

   // squares
   logic d_vld_ff;
   logic [2*MW-1:0] d_sq_ff [3];
   logic [MW-1:0] d_m_ff [3];
   logic d_zero_ff;
   logic [2:0] d_neg_ff;
   logic [SIDE_W-1:0] d_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= (2*MW)'(c_m_ff[i]) * (2*MW)'(c_m_ff[i]);
         end
         d_m_ff <= c_m_ff;
         d_zero_ff <= c_zero_ff;
         d_neg_ff <= c_neg_ff;
         d_side_ff <= c_side_ff;
      end
   end

   // sum of squares
   logic e_vld_ff;
   logic [SQW-1:0] e_sum_ff;
   logic [MW-1:0] e_m_ff [3];
   logic e_zero_ff;
   logic [2:0] e_neg_ff;
   logic [SIDE_W-1:0] e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
      end
      if (adv) begin
         e_sum_ff <= SQW'(d_sq_ff[0]) + SQW'(d_sq_ff[1]) + SQW'(d_sq_ff[2]);
         e_m_ff <= d_m_ff;
         e_zero_ff <= d_zero_ff;
         e_neg_ff <= d_neg_ff;
         e_side_ff <= d_side_ff;
      end
   end

   // square root, one result bit per stage
   logic sv_vld [0:RW];
   logic [SQW-1:0] sv_rem [0:RW];
   logic [RW-1:0] sv_root [0:RW];
   logic [MW-1:0] sv_m [0:RW][3];
   logic sv_zero [0:RW];
   logic [2:0] sv_neg [0:RW];
   logic [SIDE_W-1:0] sv_side [0:RW];

   assign sv_vld[0] = e_vld_ff;
   assign sv_rem[0] = e_sum_ff;
   assign sv_root[0] = '0;
   assign sv_m[0] = e_m_ff;
   assign sv_zero[0] = e_zero_ff;
   assign sv_neg[0] = e_neg_ff;
   assign sv_side[0] = e_side_ff;

   for (genvar k = 1; k <= RW; k++) begin : g_sqrt
      localparam int I = RW - k;
      logic vld_ff;
      logic [SQW-1:0] rem_ff;
      logic [RW-1:0] root_ff;
      logic [MW-1:0] m_ff [3];
      logic zero_ff;
      logic [2:0] neg_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [SQW-1:0] trial;
      logic take;

      assign trial = (SQW'(sv_root[k-1]) << (I + 1)) + (SQW'(1) << (2 * I));
      assign take = (sv_rem[k-1] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= sv_vld[k-1];
         end
         if (adv) begin
            rem_ff <= take ? (sv_rem[k-1] - trial) : sv_rem[k-1];
            root_ff <= take ? (sv_root[k-1] | (RW'(1) << I)) : sv_root[k-1];
            m_ff <= sv_m[k-1];
            zero_ff <= sv_zero[k-1];
            neg_ff <= sv_neg[k-1];
            side_ff <= sv_side[k-1];
         end
      end

      assign sv_vld[k] = vld_ff;
      assign sv_rem[k] = rem_ff;
      assign sv_root[k] = root_ff;
      assign sv_m[k] = m_ff;
      assign sv_zero[k] = zero_ff;
      assign sv_neg[k] = neg_ff;
      assign sv_side[k] = side_ff;
   end

   // dividends with half the length added for rounding
   logic g_vld_ff;
   logic [NUMW-1:0] g_num_ff [3];
   logic [RW-1:0] g_len_ff;
   logic g_zero_ff;
   logic [2:0] g_neg_ff;
   logic [SIDE_W-1:0] g_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= sv_vld[RW];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            g_num_ff[i] <= (NUMW'(sv_m[RW][i]) << FRAC_BITS) + NUMW'(sv_root[RW] >> 1);
         end
         g_len_ff <= sv_root[RW];
         g_zero_ff <= sv_zero[RW];
         g_neg_ff <= sv_neg[RW];
         g_side_ff <= sv_side[RW];
      end
   end

   // restoring division, three lanes, one quotient bit per stage
   logic dv_vld [0:QW];
   logic [NUMW-1:0] dv_rem [0:QW][3];
   logic [QW-1:0] dv_q [0:QW][3];
   logic [RW-1:0] dv_len [0:QW];
   logic dv_zero [0:QW];
   logic [2:0] dv_neg [0:QW];
   logic [SIDE_W-1:0] dv_side [0:QW];

   assign dv_vld[0] = g_vld_ff;
   assign dv_rem[0] = g_num_ff;
   assign dv_q[0] = '{default: '0};
   assign dv_len[0] = g_len_ff;
   assign dv_zero[0] = g_zero_ff;
   assign dv_neg[0] = g_neg_ff;
   assign dv_side[0] = g_side_ff;

   for (genvar k = 1; k <= QW; k++) begin : g_div
      localparam int I = QW - k;
      logic vld_ff;
      logic [NUMW-1:0] rem_ff [3];
      logic [QW-1:0] q_ff [3];
      logic [RW-1:0] len_ff;
      logic zero_ff;
      logic [2:0] neg_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [DW-1:0] dvs;
      logic [DW-1:0] diff [3];
      logic take [3];

      always_comb begin
         dvs = DW'(dv_len[k-1]) << I;
         for (int i = 0; i < 3; i++) begin
            take[i] = (DW'(dv_rem[k-1][i]) >= dvs);
            diff[i] = DW'(dv_rem[k-1][i]) - dvs;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= dv_vld[k-1];
         end
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= take[i] ? diff[i][NUMW-1:0] : dv_rem[k-1][i];
               q_ff[i] <= take[i] ? (dv_q[k-1][i] | (QW'(1) << I)) : dv_q[k-1][i];
            end
            len_ff <= dv_len[k-1];
            zero_ff <= dv_zero[k-1];
            neg_ff <= dv_neg[k-1];
            side_ff <= dv_side[k-1];
         end
      end

      assign dv_vld[k] = vld_ff;
      assign dv_rem[k] = rem_ff;
      assign dv_q[k] = q_ff;
      assign dv_len[k] = len_ff;
      assign dv_zero[k] = zero_ff;
      assign dv_neg[k] = neg_ff;
      assign dv_side[k] = side_ff;
   end

   // sign restore; a zero vector stays zero
   logic h_vld_ff;
   logic signed [QW-1:0] h_vec_ff [3];
   logic h_zero_ff;
   logic [SIDE_W-1:0] h_side_ff;
   logic signed [QW-1:0] h_mag [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h_mag[i] = {1'b0, dv_q[QW][i][QW-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= dv_vld[QW];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_zero[QW]) begin
               h_vec_ff[i] <= '0;
            end else if (dv_neg[QW][i]) begin
               h_vec_ff[i] <= -h_mag[i];
            end else begin
               h_vec_ff[i] <= h_mag[i];
            end
         end
         h_zero_ff <= dv_zero[QW];
         h_side_ff <= dv_side[QW];
      end
   end

   assign out_vld = h_vld_ff;
   assign out_vec = h_vec_ff;
   assign out_zero = h_zero_ff;
   assign out_side = h_side_ff;

endmodule

[rtl/look_at_view_matrix.sv]
// Right-handed look-at view matrix in signed fixed point (FRAC_BITS fraction
// bits, Q16.16 by default). Each request word carries eye, target and up
// vector; the block answers with four response words, rows 0..3 of the view
// matrix: (s, -s.eye), (u, -u.eye), (-f, f.eye), (0,0,0,1), with last_row set
// on row 3. f = normalize(target - eye), s = normalize(f x up), u = s x f.
// When f or s has zero length it is returned as zero and degenerate is set on
// all four rows. Every element saturates to 32 bits. The datapath is one
// stall-able pipeline: a request can enter on any cycle the pipe moves, and
// new requests are taken while earlier ones are still in flight (each
// normalizer is a pipelined square root plus three pipelined restoring
// dividers). The output stage hands out four rows per matrix; when it is
// busy the whole pipe holds, so nothing is dropped or repeated. No
// configuration, no state beyond the pipeline itself.
module look_at_view_matrix import lvm_pkg::*; #(
   parameter int FRAC_BITS = LVM_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   lvm_req_if.sink req_bus,
   lvm_rsp_if.source rsp_bus
);

   localparam int FW = FRAC_BITS + 2;        // unit vector component
   localparam int PRW = FW + WORD_W;         // unit x word product
   localparam int CW = PRW + 1;              // cross product of f and up
   localparam int RSW = PRW + 3;             // sums ahead of rounding
   localparam int S1W = 6 * WORD_W;
   localparam int S2W = 3 * WORD_W + 3 * FW + 1;
   localparam logic signed [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

   // shift right by FRAC_BITS, round half away from zero
   function automatic logic signed [RSW-1:0] rshift(input logic signed [RSW-1:0] v);
      logic [RSW-1:0] mag;
      logic [RSW-1:0] r;
      mag = v[RSW-1] ? RSW'(-v) : RSW'(v);
      r = (mag + (RSW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[RSW-1] ? $signed(-r) : $signed(r);
   endfunction

   // global advance: the whole pipe moves unless the last stage holds a
   // word that the row sequencer cannot take yet
   logic adv;
   logic ser_take;
   logic y10_vld_ff;

   assign adv = !y10_vld_ff || ser_take;
   assign req_bus.ready = adv;

   // stage 1: capture request
   logic i1_vld_ff;
   logic signed [WORD_W-1:0] i1_eye_ff [3];
   logic signed [WORD_W-1:0] i1_tgt_ff [3];
   logic signed [WORD_W-1:0] i1_up_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         i1_vld_ff <= 1'b0;
      end else if (adv) begin
         i1_vld_ff <= req_bus.valid;
      end
      if (adv) begin
         i1_eye_ff <= '{req_bus.eye_x, req_bus.eye_y, req_bus.eye_z};
         i1_tgt_ff <= '{req_bus.target_x, req_bus.target_y, req_bus.target_z};
         i1_up_ff <= '{req_bus.upvec_x, req_bus.upvec_y, req_bus.upvec_z};
      end
   end

   // stage 2: direction target - eye
   logic i2_vld_ff;
   logic signed [WORD_W:0] i2_d_ff [3];
   logic signed [WORD_W-1:0] i2_eye_ff [3];
   logic signed [WORD_W-1:0] i2_up_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         i2_vld_ff <= 1'b0;
      end else if (adv) begin
         i2_vld_ff <= i1_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            i2_d_ff[i] <= (WORD_W+1)'(i1_tgt_ff[i]) - (WORD_W+1)'(i1_eye_ff[i]);
         end
         i2_eye_ff <= i1_eye_ff;
         i2_up_ff <= i1_up_ff;
      end
   end

   // forward vector
   logic [S1W-1:0] n1_side_in;
   logic n1_vld;
   logic signed [FW-1:0] n1_f [3];
   logic n1_zero;
   logic [S1W-1:0] n1_side;
   logic signed [WORD_W-1:0] n1_eye [3];
   logic signed [WORD_W-1:0] n1_up [3];

   assign n1_side_in = {i2_eye_ff[0], i2_eye_ff[1], i2_eye_ff[2],
                        i2_up_ff[0], i2_up_ff[1], i2_up_ff[2]};

   lvm_norm #(
      .FRAC_BITS (FRAC_BITS),
      .IN_W      (WORD_W + 1),
      .SIDE_W    (S1W)
   ) u_norm_fwd (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (i2_vld_ff),
      .in_vec   (i2_d_ff),
      .in_side  (n1_side_in),
      .out_vld  (n1_vld),
      .out_vec  (n1_f),
      .out_zero (n1_zero),
      .out_side (n1_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_eye[i] = n1_side[(5-i)*WORD_W +: WORD_W];
         n1_up[i] = n1_side[(2-i)*WORD_W +: WORD_W];
      end
   end

   // stage 3: partial products of f x up
   logic x3_vld_ff;
   logic signed [PRW-1:0] x3_p_ff [6];
   logic signed [FW-1:0] x3_f_ff [3];
   logic signed [WORD_W-1:0] x3_eye_ff [3];
   logic x3_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x3_vld_ff <= 1'b0;
      end else if (adv) begin
         x3_vld_ff <= n1_vld;
      end
      if (adv) begin
         x3_p_ff[0] <= PRW'(n1_f[1]) * PRW'(n1_up[2]);
         x3_p_ff[1] <= PRW'(n1_f[2]) * PRW'(n1_up[1]);
         x3_p_ff[2] <= PRW'(n1_f[2]) * PRW'(n1_up[0]);
         x3_p_ff[3] <= PRW'(n1_f[0]) * PRW'(n1_up[2]);
         x3_p_ff[4] <= PRW'(n1_f[0]) * PRW'(n1_up[1]);
         x3_p_ff[5] <= PRW'(n1_f[1]) * PRW'(n1_up[0]);
         x3_f_ff <= n1_f;
         x3_eye_ff <= n1_eye;
         x3_deg_ff <= n1_zero;
      end
   end

   // stage 4: cross product
   logic x4_vld_ff;
   logic signed [CW-1:0] x4_c_ff [3];
   logic signed [FW-1:0] x4_f_ff [3];
   logic signed [WORD_W-1:0] x4_eye_ff [3];
   logic x4_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x4_vld_ff <= 1'b0;
      end else if (adv) begin
         x4_vld_ff <= x3_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            x4_c_ff[i] <= CW'(x3_p_ff[2*i]) - CW'(x3_p_ff[2*i+1]);
         end
         x4_f_ff <= x3_f_ff;
         x4_eye_ff <= x3_eye_ff;
         x4_deg_ff <= x3_deg_ff;
      end
   end

   // side vector
   logic [S2W-1:0] n2_side_in;
   logic n2_vld;
   logic signed [FW-1:0] n2_s [3];
   logic n2_zero;
   logic [S2W-1:0] n2_side;
   logic signed [WORD_W-1:0] n2_eye [3];
   logic signed [FW-1:0] n2_f [3];
   logic n2_deg;

   assign n2_side_in = {x4_eye_ff[0], x4_eye_ff[1], x4_eye_ff[2],
                        x4_f_ff[0], x4_f_ff[1], x4_f_ff[2], x4_deg_ff};

   lvm_norm #(
      .FRAC_BITS (FRAC_BITS),
      .IN_W      (CW),
      .SIDE_W    (S2W)
   ) u_norm_side (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (x4_vld_ff),
      .in_vec   (x4_c_ff),
      .in_side  (n2_side_in),
      .out_vld  (n2_vld),
      .out_vec  (n2_s),
      .out_zero (n2_zero),
      .out_side (n2_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n2_eye[i] = n2_side[1 + 3*FW + (2-i)*WORD_W +: WORD_W];
         n2_f[i] = n2_side[1 + (2-i)*FW +: FW];
      end
      n2_deg = n2_side[0] | n2_zero;
   end

   // stage 5: s x f terms, s.eye and f.eye terms
   logic y5_vld_ff;
   logic signed [2*FW-1:0] y5_sf_ff [6];
   logic signed [PRW-1:0] y5_se_ff [3];
   logic signed [PRW-1:0] y5_fe_ff [3];
   logic signed [FW-1:0] y5_s_ff [3];
   logic signed [FW-1:0] y5_f_ff [3];
   logic signed [WORD_W-1:0] y5_eye_ff [3];
   logic y5_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         y5_vld_ff <= 1'b0;
      end else if (adv) begin
         y5_vld_ff <= n2_vld;
      end
      if (adv) begin
         y5_sf_ff[0] <= (2*FW)'(n2_s[1]) * (2*FW)'(n2_f[2]);
         y5_sf_ff[1] <= (2*FW)'(n2_s[2]) * (2*FW)'(n2_f[1]);
         y5_sf_ff[2] <= (2*FW)'(n2_s[2]) * (2*FW)'(n2_f[0]);
         y5_sf_ff[3] <= (2*FW)'(n2_s[0]) * (2*FW)'(n2_f[2]);
         y5_sf_ff[4] <= (2*FW)'(n2_s[0]) * (2*FW)'(n2_f[1]);
         y5_sf_ff[5] <= (2*FW)'(n2_s[1]) * (2*FW)'(n2_f[0]);
         for (int i = 0; i < 3; i++) begin
            y5_se_ff[i] <= PRW'(n2_s[i]) * PRW'(n2_eye[i]);
            y5_fe_ff[i] <= PRW'(n2_f[i]) * PRW'(n2_eye[i]);
         end
         y5_s_ff <= n2_s;
         y5_f_ff <= n2_f;
         y5_eye_ff <= n2_eye;
         y5_deg_ff <= n2_deg;
      end
   end

   // stage 6: raw u and the two dot sums
   logic y6_vld_ff;
   logic signed [RSW-1:0] y6_ur_ff [3];
   logic signed [RSW-1:0] y6_ds_ff;
   logic signed [RSW-1:0] y6_df_ff;
   logic signed [FW-1:0] y6_s_ff [3];
   logic signed [FW-1:0] y6_f_ff [3];
   logic signed [WORD_W-1:0] y6_eye_ff [3];
   logic y6_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         y6_vld_ff <= 1'b0;
      end else if (adv) begin
         y6_vld_ff <= y5_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            y6_ur_ff[i] <= RSW'(y5_sf_ff[2*i]) - RSW'(y5_sf_ff[2*i+1]);
         end
         y6_ds_ff <= RSW'(y5_se_ff[0]) + RSW'(y5_se_ff[1]) + RSW'(y5_se_ff[2]);
         y6_df_ff <= RSW'(y5_fe_ff[0]) + RSW'(y5_fe_ff[1]) + RSW'(y5_fe_ff[2]);
         y6_s_ff <= y5_s_ff;
         y6_f_ff <= y5_f_ff;
         y6_eye_ff <= y5_eye_ff;
         y6_deg_ff <= y5_deg_ff;
      end
   end

   // stage 7: round u, finish translations of rows 0 and 2
   logic y7_vld_ff;
   logic signed [FW-1:0] y7_u_ff [3];
   logic signed [WORD_W-1:0] y7_ts_ff;
   logic signed [WORD_W-1:0] y7_tf_ff;
   logic signed [FW-1:0] y7_s_ff [3];
   logic signed [FW-1:0] y7_f_ff [3];
   logic signed [WORD_W-1:0] y7_eye_ff [3];
   logic y7_deg_ff;
   logic signed [RSW-1:0] y7_ur [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         y7_ur[i] = rshift(y6_ur_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y7_vld_ff <= 1'b0;
      end else if (adv) begin
         y7_vld_ff <= y6_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            // |u| stays within one unit, fits the unit vector width
            y7_u_ff[i] <= y7_ur[i][FW-1:0];
         end
         y7_ts_ff <= sat_word(SAT_IN_W'(-rshift(y6_ds_ff)));
         y7_tf_ff <= sat_word(SAT_IN_W'(rshift(y6_df_ff)));
         y7_s_ff <= y6_s_ff;
         y7_f_ff <= y6_f_ff;
         y7_eye_ff <= y6_eye_ff;
         y7_deg_ff <= y6_deg_ff;
      end
   end

   // stage 8: u.eye terms
   logic y8_vld_ff;
   logic signed [PRW-1:0] y8_ue_ff [3];
   logic signed [FW-1:0] y8_u_ff [3];
   logic signed [WORD_W-1:0] y8_ts_ff;
   logic signed [WORD_W-1:0] y8_tf_ff;
   logic signed [FW-1:0] y8_s_ff [3];
   logic signed [FW-1:0] y8_f_ff [3];
   logic y8_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         y8_vld_ff <= 1'b0;
      end else if (adv) begin
         y8_vld_ff <= y7_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            y8_ue_ff[i] <= PRW'(y7_u_ff[i]) * PRW'(y7_eye_ff[i]);
         end
         y8_u_ff <= y7_u_ff;
         y8_ts_ff <= y7_ts_ff;
         y8_tf_ff <= y7_tf_ff;
         y8_s_ff <= y7_s_ff;
         y8_f_ff <= y7_f_ff;
         y8_deg_ff <= y7_deg_ff;
      end
   end

   // stage 9: u.eye sum
   logic y9_vld_ff;
   logic signed [RSW-1:0] y9_du_ff;
   logic signed [FW-1:0] y9_u_ff [3];
   logic signed [WORD_W-1:0] y9_ts_ff;
   logic signed [WORD_W-1:0] y9_tf_ff;
   logic signed [FW-1:0] y9_s_ff [3];
   logic signed [FW-1:0] y9_f_ff [3];
   logic y9_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         y9_vld_ff <= 1'b0;
      end else if (adv) begin
         y9_vld_ff <= y8_vld_ff;
      end
      if (adv) begin
         y9_du_ff <= RSW'(y8_ue_ff[0]) + RSW'(y8_ue_ff[1]) + RSW'(y8_ue_ff[2]);
         y9_u_ff <= y8_u_ff;
         y9_ts_ff <= y8_ts_ff;
         y9_tf_ff <= y8_tf_ff;
         y9_s_ff <= y8_s_ff;
         y9_f_ff <= y8_f_ff;
         y9_deg_ff <= y8_deg_ff;
      end
   end

   // stage 10: row 1 translation; all rows ready
   logic signed [WORD_W-1:0] y10_tu_ff;
   logic signed [FW-1:0] y10_u_ff [3];
   logic signed [WORD_W-1:0] y10_ts_ff;
   logic signed [WORD_W-1:0] y10_tf_ff;
   logic signed [FW-1:0] y10_s_ff [3];
   logic signed [FW-1:0] y10_f_ff [3];
   logic y10_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         y10_vld_ff <= 1'b0;
      end else if (adv) begin
         y10_vld_ff <= y9_vld_ff;
      end
      if (adv) begin
         y10_tu_ff <= sat_word(SAT_IN_W'(-rshift(y9_du_ff)));
         y10_u_ff <= y9_u_ff;
         y10_ts_ff <= y9_ts_ff;
         y10_tf_ff <= y9_tf_ff;
         y10_s_ff <= y9_s_ff;
         y10_f_ff <= y9_f_ff;
         y10_deg_ff <= y9_deg_ff;
      end
   end

   // row sequencer: holds one matrix, hands out a row per response word
   logic ser_vld_ff;
   logic [1:0] ser_idx_ff;
   logic signed [WORD_W-1:0] ser_elem_ff [3][4];
   logic ser_deg_ff;
   logic rsp_fire;

   assign rsp_fire = ser_vld_ff && rsp_bus.ready;
   assign ser_take = !ser_vld_ff || (rsp_fire && ser_idx_ff == ROW_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         ser_idx_ff <= ROW_SIDE;
      end else if (ser_take) begin
         ser_vld_ff <= y10_vld_ff;
         ser_idx_ff <= ROW_SIDE;
      end else if (rsp_fire) begin
         ser_idx_ff <= ser_idx_ff + 2'd1;
      end
      if (ser_take) begin
         for (int i = 0; i < 3; i++) begin
            ser_elem_ff[0][i] <= WORD_W'(y10_s_ff[i]);
            ser_elem_ff[1][i] <= WORD_W'(y10_u_ff[i]);
            ser_elem_ff[2][i] <= WORD_W'(-y10_f_ff[i]);
         end
         ser_elem_ff[0][3] <= y10_ts_ff;
         ser_elem_ff[1][3] <= y10_tu_ff;
         ser_elem_ff[2][3] <= y10_tf_ff;
         ser_deg_ff <= y10_deg_ff;
      end
   end

   always_comb begin
      rsp_bus.elem0 = '0;
      rsp_bus.elem1 = '0;
      rsp_bus.elem2 = '0;
      rsp_bus.elem3 = ONE;
      case (ser_idx_ff)
         ROW_SIDE: begin
            rsp_bus.elem0 = ser_elem_ff[0][0];
            rsp_bus.elem1 = ser_elem_ff[0][1];
            rsp_bus.elem2 = ser_elem_ff[0][2];
            rsp_bus.elem3 = ser_elem_ff[0][3];
         end
         ROW_UP: begin
            rsp_bus.elem0 = ser_elem_ff[1][0];
            rsp_bus.elem1 = ser_elem_ff[1][1];
            rsp_bus.elem2 = ser_elem_ff[1][2];
            rsp_bus.elem3 = ser_elem_ff[1][3];
         end
         ROW_FWD: begin
            rsp_bus.elem0 = ser_elem_ff[2][0];
            rsp_bus.elem1 = ser_elem_ff[2][1];
            rsp_bus.elem2 = ser_elem_ff[2][2];
            rsp_bus.elem3 = ser_elem_ff[2][3];
         end
         ROW_LAST: begin
            rsp_bus.elem3 = ONE;
         end
         default: begin
            rsp_bus.elem3 = ONE;
         end
      endcase
   end

   assign rsp_bus.valid = ser_vld_ff;
   assign rsp_bus.row_index = ser_idx_ff;
   assign rsp_bus.last_row = (ser_idx_ff == ROW_LAST);
   assign rsp_bus.degenerate = ser_deg_ff;

`ifndef ASSERT_OFF
   // rows of one matrix go out in order, each row index one above the last
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && ser_idx_ff != ROW_LAST) |=>
         (ser_vld_ff && ser_idx_ff == $past(ser_idx_ff) + 2'd1))
      else $error("row sequence broken");

   // a new matrix always starts at row 0
   a_row_start: assert property (@(posedge clock) disable iff (reset)
      $rose(ser_vld_ff) |-> (ser_idx_ff == ROW_SIDE))
      else $error("matrix does not start at row 0");

   // degenerate flag is the same on every row of a matrix
   a_deg_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && ser_idx_ff != ROW_LAST) |=> $stable(ser_deg_ff))
      else $error("degenerate flag changed within a matrix");

   // pipe holds while the last stage waits on the sequencer
   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      (y10_vld_ff && !ser_take) |=> (y10_vld_ff && $stable(y10_tu_ff)))
      else $error("last stage lost its word");
`endif

endmodule
